>>> sv/tepq_pkg.sv
// Shared types, codes and defaults for the timed event priority queue.
package tepq_pkg;

  // Fixed field widths of the item interface
  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned OCC_W    = 5;

  // Parameter defaults
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PLACE,
    S_HEAD_RD,
    S_HEAD
  } state_e;

  typedef struct packed {
    op_e               mode;
    logic [ID_W-1:0]   event_id;
    logic [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic              head_valid;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_time;
    status_e           status;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

endpackage

>>> sv/timed_event_priority_queue.sv
// Timed event priority queue: sorted slot store walked by a read-modify-write sequencer.
// Insert walks down the entries with a later time, shifting each up one slot, then places the item;
// pop and remove walk every queued entry; clear and refused items go straight to the head read.
// One item at a time: each step is a read of the slot store, a compare, and a write back.
// The output register lets the next item be taken while a result waits.
// Reset (asynchronous, active low) empties the queue; slot contents are not cleared.
module timed_event_priority_queue import tepq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned ID_BITS  = ID_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned SID = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned EW  = SID + TIME_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              found_q, found_d;
  op_e               op_q, op_d;
  logic [SID-1:0]    id_q, id_d;
  logic [TIME_W-1:0] time_q, time_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [CW-1:0]     idx_m1, idx_p1;
  logic [SID-1:0]    rd_id;
  logic [TIME_W-1:0] rd_time;
  logic              later, hit, last, out_free, accept;

  tepq_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW),
    .DW   (EW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Decode of the slot just read and of the walk position
  assign rd_id    = rdata[EW-1:TIME_W];
  assign rd_time  = rdata[TIME_W-1:0];
  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;
  assign later    = rd_time > time_q;
  assign hit      = !found_q && ((op_q == OP_POP) || (rd_id == id_q));
  assign last     = idx_p1 == count_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.mode)
            OP_INSERT: begin
              if (count_q == CAP)         state_d = S_HEAD_RD;
              else if (count_q == '0)     state_d = S_PLACE;
              else                        state_d = S_RD;
            end
            OP_POP, OP_REMOVE: begin
              state_d = (count_q == '0) ? S_HEAD_RD : S_RD;
            end
            default: state_d = S_HEAD_RD;
          endcase
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (op_q == OP_INSERT) begin
          if (!later)                 state_d = S_HEAD_RD;
          else if (idx_q == CW'(1))   state_d = S_PLACE;
          else                        state_d = S_RD;
        end else begin
          state_d = last ? S_HEAD_RD : S_RD;
        end
      end
      S_PLACE:   state_d = S_HEAD_RD;
      S_HEAD_RD: state_d = S_HEAD;
      S_HEAD:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Slot store controls and input handshake
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = {id_q, time_q};
    re    = 1'b0;
    raddr = idx_q[AW-1:0];
    case (state_q)
      S_RD: begin
        re    = 1'b1;
        raddr = (op_q == OP_INSERT) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
      end
      S_CMP: begin
        if (op_q == OP_INSERT) begin
          // Shift the later entry up one slot, or drop the new one in
          we    = 1'b1;
          wdata = later ? rdata : {id_q, time_q};
        end else if (found_q) begin
          // Close the gap left by the removed entry
          we    = 1'b1;
          waddr = idx_m1[AW-1:0];
          wdata = rdata;
        end
      end
      S_PLACE: we = 1'b1;
      S_HEAD_RD: begin
        re    = 1'b1;
        raddr = '0;
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    op_d        = op_q;
    id_d        = id_q;
    time_d      = time_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = in_item_i.mode;
          id_d     = in_item_i.event_id[SID-1:0];
          time_d   = in_item_i.event_time;
          status_d = ST_OK;
          found_d  = 1'b0;
          idx_d    = '0;
          case (in_item_i.mode)
            OP_INSERT: begin
              if (count_q == CAP) status_d = ST_FULL;
              idx_d = count_q;
            end
            OP_POP, OP_REMOVE: begin
              if (count_q == '0) status_d = ST_MISS;
            end
            default: count_d = '0;
          endcase
        end
      end
      S_CMP: begin
        if (op_q == OP_INSERT) begin
          if (later) begin
            idx_d = idx_m1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end else begin
          if (hit) found_d = 1'b1;
          idx_d = idx_p1;
          if (last) begin
            if (found_q || hit) count_d = count_q - 1'b1;
            else                status_d = ST_MISS;
          end
        end
      end
      S_PLACE: count_d = count_q + 1'b1;
      S_HEAD: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.head_valid     = (count_q != '0);
          out_d.head_id        = (count_q != '0) ? ID_W'(rd_id) : '0;
          out_d.head_time      = (count_q != '0) ? rd_time : '0;
          out_d.status         = status_q;
          out_d.occupancy      = OCC_W'(count_q);
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    found_q  <= found_d;
    op_q     <= op_d;
    id_q     <= id_d;
    time_q   <= time_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("queue count above capacity");

  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> $past(state_q) == S_RD)
    else $error("compare without a preceding slot read");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD && out_free && status_q == ST_FULL) |-> count_q == CAP)
    else $error("insert dropped while queue not full");

endmodule

>>> sv/tepq_mem.sv
// Slot store: one write port, one read port, registered read data.
module tepq_mem import tepq_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(CAPACITY_DEF),
  parameter int unsigned DW    = ID_BITS_DEF + TIME_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the timed event priority queue: directed and random operation items.
module tb_top;
  import tepq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = CAPACITY_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 60;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // Own copy of the sorted event store
  logic [TIME_W-1:0] ev_times [CAP];
  logic [ID_W-1:0]   ev_ids   [CAP];
  int                ev_count;

  out_item_t pending_heads [$];
  int        err_count;
  bit        calm;
  int        stall_cycles;

  timed_event_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Close the gap at pos, moving later entries one slot toward the head
  function automatic void close_gap(int pos);
    int k;
    for (k = pos; k + 1 < ev_count; k++) begin
      ev_times[k] = ev_times[k + 1];
      ev_ids[k]   = ev_ids[k + 1];
    end
    ev_count--;
  endfunction

  // Apply one operation to the store and return the head report it gives
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t r;
    status_e   st;
    int        pos;
    int        k;
    bit        found;
    st    = ST_OK;
    pos   = 0;
    found = 1'b0;
    case (it.mode)
      OP_INSERT: begin
        if (ev_count >= CAP) begin
          st = ST_FULL;
        end else begin
          while (pos < ev_count && ev_times[pos] <= it.event_time) pos++;
          for (k = ev_count; k > pos; k--) begin
            ev_times[k] = ev_times[k - 1];
            ev_ids[k]   = ev_ids[k - 1];
          end
          ev_times[pos] = it.event_time;
          ev_ids[pos]   = it.event_id;
          ev_count++;
        end
      end
      OP_POP: begin
        if (ev_count == 0) st = ST_MISS;
        else close_gap(0);
      end
      OP_REMOVE: begin
        for (k = 0; k < ev_count && !found; k++) begin
          if (ev_ids[k] == it.event_id) begin
            found = 1'b1;
            pos   = k;
          end
        end
        if (found) close_gap(pos);
        else st = ST_MISS;
      end
      default: ev_count = 0;
    endcase
    r.head_valid = (ev_count > 0);
    r.head_id    = (ev_count > 0) ? ev_ids[0] : '0;
    r.head_time  = (ev_count > 0) ? ev_times[0] : '0;
    r.status     = st;
    r.occupancy  = ev_count[OCC_W-1:0];
    return r;
  endfunction

  // Send one item, with an occasional gap before it; predict on acceptance
  task automatic send_item(input op_e m, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t);
    in_item_t it;
    it.mode       = m;
    it.event_id   = id;
    it.event_time = t;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_heads.insert(pending_heads.size(), apply_op(it));
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 3);
    if (r < 2) return TIME_W'($urandom_range(0, 31));
    if (r == 2) return {32'h0000_0001, 32'($urandom_range(0, 255))};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 7));
    return ID_W'($urandom);
  endfunction

  // Pop, remove and clear on an empty queue
  task automatic test_empty_queue();
    send_item(OP_POP, '0, '0);
    send_item(OP_REMOVE, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_REMOVE, '1, '1);
  endtask

  // Extreme times, FIFO order on equal times, duplicate handle removal
  task automatic test_time_order();
    send_item(OP_INSERT, 16'hffff, '1);
    send_item(OP_INSERT, 16'h0000, '0);
    send_item(OP_INSERT, 16'h0001, 64'd5);
    send_item(OP_INSERT, 16'h0002, 64'd5);
    send_item(OP_INSERT, 16'h0007, 64'd5);
    send_item(OP_INSERT, 16'h0007, 64'd3);
    send_item(OP_REMOVE, 16'h0007, '0);
    send_item(OP_POP, 16'h0000, '0);
    send_item(OP_REMOVE, 16'h1234, '0);
  endtask

  // Fill to capacity, refused insert, then clear a full queue
  task automatic test_full_queue();
    while (ev_count < CAP) send_item(OP_INSERT, pick_id(), pick_time());
    send_item(OP_INSERT, 16'hffff, '1);
    send_item(OP_CLEAR, '0, '0);
  endtask

  // Random mix; the insert share moves between phases to sweep occupancy
  task automatic test_random_mix(input int n_items);
    int             i;
    int             ins_pct;
    int             r;
    logic [ID_W-1:0] id;
    ins_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: ins_pct = 30;
          1: ins_pct = 50;
          2: ins_pct = 70;
          default: ins_pct = 90;
        endcase
      end
      calm = (i >= 500 && i < 800);
      if ($urandom_range(0, 99) < ins_pct) begin
        send_item(OP_INSERT, pick_id(), pick_time());
      end else begin
        r = $urandom_range(0, 39);
        if (r == 0) begin
          send_item(OP_CLEAR, pick_id(), pick_time());
        end else if (r < 20) begin
          send_item(OP_POP, pick_id(), pick_time());
        end else begin
          // mostly a handle that is queued, sometimes a likely miss
          if (ev_count > 0 && $urandom_range(0, 3) != 0)
            id = ev_ids[$urandom_range(0, ev_count - 1)];
          else
            id = pick_id();
          send_item(OP_REMOVE, id, pick_time());
        end
      end
    end
    calm = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_heads.size() == 0) begin
        $display("%0t: unexpected result, actual %0h", $time, out_item_o);
        err_count++;
      end else begin
        want = pending_heads[0];
        pending_heads.delete(0);
        check_field("head_valid", TIME_W'(want.head_valid), TIME_W'(out_item_o.head_valid));
        check_field("head_id", TIME_W'(want.head_id), TIME_W'(out_item_o.head_id));
        check_field("head_time", want.head_time, out_item_o.head_time);
        check_field("status", TIME_W'(want.status), TIME_W'(out_item_o.status));
        check_field("occupancy", TIME_W'(want.occupancy), TIME_W'(out_item_o.occupancy));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 21);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timed_event_priority_queue regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_ready_i  = 1'b0;
    ev_count     = 0;
    err_count    = 0;
    calm         = 1'b0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_queue();
    test_time_order();
    test_full_queue();
    test_random_mix(1300);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("timed_event_priority_queue regression: pass");
    end else begin
      $display("timed_event_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
